>>> rtl/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, constants and tables of the polar sector density block.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int unsigned DIRECTIONS_DEF = 16;

  localparam int unsigned POS_W     = 24;  // Q16.8 position
  localparam int unsigned DELTA_W   = 25;  // point minus center
  localparam int unsigned MAG_W     = 24;  // magnitude of a delta
  localparam int unsigned SUMSQ_W   = 49;  // dx^2 + dy^2
  localparam int unsigned DIST_W    = 25;  // floor(sqrt(sum))
  localparam int unsigned LIMIT_W   = 24;
  localparam int unsigned NORM_W    = 16;
  localparam int unsigned ACC_W     = 24;
  localparam int unsigned VAL_W     = 17;  // Q1.16 value
  localparam int unsigned TURN_W    = 17;  // 0..65536 per full turn
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned SEC_OUT_W = 5;
  localparam int unsigned NUM_W     = 41;  // dividend width
  localparam int unsigned DIV_STEPS = 17;  // quotient bits
  localparam int unsigned ROOT_STEPS = 25; // root bits
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;

  localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [ACC_W-1:0] ACC_MAX = 24'hFFFFFF;

  // register indexes
  localparam logic [2:0] REG_CENTER_X      = 3'd0;
  localparam logic [2:0] REG_CENTER_Y      = 3'd1;
  localparam logic [2:0] REG_NEAREST_LIMIT = 3'd2;
  localparam logic [2:0] REG_NEAR_LIMIT    = 3'd3;
  localparam logic [2:0] REG_MID_LIMIT     = 3'd4;
  localparam logic [2:0] REG_NEAR_NORM     = 3'd5;
  localparam logic [2:0] REG_MID_NORM      = 3'd6;

  typedef enum logic [KIND_W-1:0] {
    KIND_NEAREST = 2'd0,
    KIND_NEAR    = 2'd1,
    KIND_MID     = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_START,
    ST_SOLVE,
    ST_SECTOR,
    ST_NEAREST_START,
    ST_NEAREST_WAIT,
    ST_BAND_START,
    ST_BAND_WAIT,
    ST_FINISH,
    ST_EMIT_PREP,
    ST_EMIT_WAIT,
    ST_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic signed [POS_W-1:0] point_x;
    logic signed [POS_W-1:0] point_y;
    logic                    has_point;
    logic                    last_point;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    feature_kind;
    logic [SEC_OUT_W-1:0] sector;
    logic [VAL_W-1:0]     feature_value;
    logic                 last_result;
  } out_item_t;

  // divider result: done pulse, quotient beyond 17 bits, quotient
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [VAL_W-1:0] quot;
  } div_res_t;

  // arctangent of 2^-i in units of 1/65536 turn
  function automatic logic [13:0] atan_turn(input logic [3:0] idx);
    logic [13:0] v;
    case (idx)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/psd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div
// Restoring divider, one quotient bit per cycle, 17-bit quotient. A dividend
// whose quotient would need more bits is flagged as overflow up front.
// ----------------------------------------------------------------------------
module psd_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [psd_pkg::NUM_W-1:0]       num_i,
  input  logic [psd_pkg::LIMIT_W-1:0]     den_i,
  output psd_pkg::div_res_t               res_o
);

  localparam int unsigned CNT_W = $clog2(psd_pkg::DIV_STEPS + 1);
  localparam int unsigned LW    = psd_pkg::LIMIT_W;
  localparam int unsigned QW    = psd_pkg::VAL_W;

  logic             busy_q, done_q, ovf_q;
  logic [CNT_W-1:0] cnt_q;
  logic [LW-1:0]    rem_q, den_q;
  logic [QW-1:0]    low_q, quot_q;
  logic [LW:0]      trial;
  logic             fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_q, low_q[QW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(psd_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      ovf_q <= (num_i[psd_pkg::NUM_W-1:QW] >= den_i);
      rem_q <= num_i[psd_pkg::NUM_W-1:QW];
      low_q <= num_i[QW-1:0];
    end else if (busy_q) begin
      rem_q  <= fits ? LW'(trial - {1'b0, den_q}) : trial[LW-1:0];
      low_q  <= {low_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quot = quot_q;

endmodule

>>> rtl/psd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_isqrt
// Integer square root, one root bit per cycle, 25 root bits.
// ----------------------------------------------------------------------------
module psd_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psd_pkg::SUMSQ_W-1:0]   rad_i,
  output logic                          done_o,
  output logic [psd_pkg::DIST_W-1:0]    root_o
);

  localparam int unsigned RW    = psd_pkg::DIST_W;
  localparam int unsigned PW    = 2 * RW;
  localparam int unsigned CNT_W = $clog2(psd_pkg::ROOT_STEPS + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PW-1:0]    rad_q;
  logic [RW+1:0]    rem_q, rem_n, trial;
  logic [RW-1:0]    root_q;

  // bring down two radicand bits, try root*4+1
  assign rem_n = {rem_q[RW-1:0], rad_q[PW-1:PW-2]};
  assign trial = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(psd_pkg::ROOT_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {1'b0, rad_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[PW-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> rtl/psd_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_cordic
// Vectoring CORDIC, one rotation per cycle, giving the angle of a vector
// as a turn count from -pi (0..65536). Axis vectors are exact.
// ----------------------------------------------------------------------------
module psd_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [psd_pkg::DELTA_W-1:0]  dx_i,
  input  logic signed [psd_pkg::DELTA_W-1:0]  dy_i,
  output logic                                done_o,
  output logic [psd_pkg::TURN_W-1:0]          turn_o
);

  localparam int unsigned XW = 28;
  localparam int unsigned ZW = 18;
  localparam int unsigned BW = 20;

  logic                 busy_q, done_q;
  logic [3:0]           cnt_q;
  logic signed [XW-1:0] x_q, y_q, xs, ys, x0, y0;
  logic signed [ZW-1:0] z_q, at;
  logic signed [BW-1:0] base_q, tsum;

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign at = ZW'(psd_pkg::atan_turn(cnt_q));
  assign x0 = XW'(dx_i);
  assign y0 = XW'(dy_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        // axis vectors finish at once
        if (dy_i == '0 || dx_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 4'(psd_pkg::CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // rotation datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      z_q <= '0;
      if (dy_i == '0) begin
        base_q <= (dx_i > 0) ? BW'(0) : BW'(32768);
      end else if (dx_i == '0) begin
        base_q <= (dy_i > 0) ? BW'(16384) : -BW'(16384);
      end else if (dx_i < 0) begin
        base_q <= (dy_i >= 0) ? BW'(32768) : -BW'(32768);
        x_q    <= -x0;
        y_q    <= -y0;
      end else begin
        base_q <= '0;
        x_q    <= x0;
        y_q    <= y0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
  end

  // turn from -pi, clamped to one full turn
  assign tsum = base_q + {{(BW-ZW){z_q[ZW-1]}}, z_q} + BW'(32768);

  always_comb begin
    if (tsum < 0) begin
      turn_o = '0;
    end else if (tsum > BW'(65536)) begin
      turn_o = psd_pkg::ONE_Q16;
    end else begin
      turn_o = tsum[psd_pkg::TURN_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

>>> rtl/polar_sector_density_features_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_sector_density_features_core
// Polar sector histogram of a point stream with nearest and density features.
// ----------------------------------------------------------------------------
// One item at a time. A point item squares dx and dy on one multiplier,
// runs the bit-serial square root (the 16-step CORDIC angle runs
// alongside), then computes the nearest value and, for a point within the
// mid limit, the band weight as 17-step divisions on the shared divider.
// A zero-distance point skips the root and the divisions. An item with the
// last mark then emits 3*DIRECTIONS results; each density result takes one
// divider pass, a nearest result none, and an output stall holds each one.
// Bins clear at once after the final result is taken.
module polar_sector_density_features_core #(
  parameter int unsigned DIRECTIONS = psd_pkg::DIRECTIONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  psd_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output psd_pkg::out_item_t             out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psd_pkg::ADDR_W-1:0]     paddr,
  input  logic [psd_pkg::DATA_W-1:0]     pwdata,
  output logic [psd_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  localparam int unsigned SECW = (DIRECTIONS > 1) ? $clog2(DIRECTIONS) : 1;
  localparam int unsigned LW   = psd_pkg::LIMIT_W;
  localparam int unsigned DW   = psd_pkg::DIST_W;
  localparam int unsigned VW   = psd_pkg::VAL_W;
  localparam int unsigned AW   = psd_pkg::ACC_W;
  localparam int unsigned NW   = psd_pkg::NUM_W;
  localparam int unsigned TW   = psd_pkg::TURN_W;
  localparam logic [SECW-1:0] SEC_LAST = SECW'(DIRECTIONS - 1);
  localparam logic [4:0]      DIR_L    = 5'(DIRECTIONS);

  // configuration registers
  logic [LW-1:0]             center_x_q, center_y_q;
  logic [LW-1:0]             nearest_limit_q, near_limit_q, mid_limit_q;
  logic [psd_pkg::NORM_W-1:0] near_norm_q, mid_norm_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q      <= '0;
      center_y_q      <= '0;
      nearest_limit_q <= 24'd65536;
      near_limit_q    <= 24'd25600;
      mid_limit_q     <= 24'd51200;
      near_norm_q     <= 16'd1280;
      mid_norm_q      <= 16'd2560;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        psd_pkg::REG_CENTER_X:      center_x_q      <= pwdata[LW-1:0];
        psd_pkg::REG_CENTER_Y:      center_y_q      <= pwdata[LW-1:0];
        psd_pkg::REG_NEAREST_LIMIT: nearest_limit_q <= pwdata[LW-1:0];
        psd_pkg::REG_NEAR_LIMIT:    near_limit_q    <= pwdata[LW-1:0];
        psd_pkg::REG_MID_LIMIT:     mid_limit_q     <= pwdata[LW-1:0];
        psd_pkg::REG_NEAR_NORM:     near_norm_q     <= pwdata[psd_pkg::NORM_W-1:0];
        psd_pkg::REG_MID_NORM:      mid_norm_q      <= pwdata[psd_pkg::NORM_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      psd_pkg::REG_CENTER_X:      prdata = 32'(center_x_q);
      psd_pkg::REG_CENTER_Y:      prdata = 32'(center_y_q);
      psd_pkg::REG_NEAREST_LIMIT: prdata = 32'(nearest_limit_q);
      psd_pkg::REG_NEAR_LIMIT:    prdata = 32'(near_limit_q);
      psd_pkg::REG_MID_LIMIT:     prdata = 32'(mid_limit_q);
      psd_pkg::REG_NEAR_NORM:     prdata = 32'(near_norm_q);
      psd_pkg::REG_MID_NORM:      prdata = 32'(mid_norm_q);
      default:                    prdata = '0;
    endcase
  end

  // sequencer
  psd_pkg::state_e state_q, state_d;
  logic                           last_q;
  logic signed [psd_pkg::DELTA_W-1:0] dx_q, dy_q;
  logic [psd_pkg::SUMSQ_W-1:0]    sum_q;
  logic [DW-1:0]                  d_q;
  logic [SECW-1:0]                sec_q;
  psd_pkg::kind_e                 kind_q;
  logic                           band_mid_q;
  logic [VW-1:0]                  val_q;

  // bins, an entry without its valid bit reads as cleared
  logic [VW-1:0]   nearest_q [DIRECTIONS];
  logic [AW-1:0]   near_acc_q [DIRECTIONS];
  logic [AW-1:0]   mid_acc_q [DIRECTIONS];
  logic [DIRECTIONS-1:0] vld_q;
  logic [VW-1:0]   nearest_rd;
  logic [AW-1:0]   near_rd, mid_rd;

  assign nearest_rd = vld_q[sec_q] ? nearest_q[sec_q] : psd_pkg::ONE_Q16;
  assign near_rd    = vld_q[sec_q] ? near_acc_q[sec_q] : '0;
  assign mid_rd     = vld_q[sec_q] ? mid_acc_q[sec_q] : '0;

  // shared units
  logic                    div_start, sqrt_start, cordic_start;
  logic [NW-1:0]           div_num;
  logic [LW-1:0]           div_den;
  psd_pkg::div_res_t       div_res;
  logic                    sqrt_done, cordic_done;
  logic [DW-1:0]           root;
  logic [TW-1:0]           turn;

  psd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .res_o   (div_res)
  );

  psd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sum_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  psd_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .dx_i    (dx_q),
    .dy_i    (dy_q),
    .done_o  (cordic_done),
    .turn_o  (turn)
  );

  // squaring multiplier, one square per cycle
  logic [psd_pkg::MAG_W-1:0]     mag;
  logic signed [psd_pkg::DELTA_W-1:0] sq_src, sq_neg;
  logic [2*psd_pkg::MAG_W-1:0]   square;

  assign sq_src = (state_q == psd_pkg::ST_SQ_X) ? dx_q : dy_q;
  assign sq_neg = -sq_src;
  assign mag    = sq_src[psd_pkg::DELTA_W-1] ? sq_neg[psd_pkg::MAG_W-1:0]
                                             : sq_src[psd_pkg::MAG_W-1:0];
  assign square = mag * mag;

  // sector from the turn count
  logic [TW+4:0]  sec_prod;
  logic [5:0]     sec_full;
  logic [SECW-1:0] sec_new;

  assign sec_prod = (TW+5)'(turn) * (TW+5)'(DIR_L);
  assign sec_full = sec_prod[TW+4:16];
  assign sec_new  = (sec_full > 6'(DIRECTIONS - 1)) ? SEC_LAST : SECW'(sec_full);

  // band choice and operands
  logic          in_near, in_mid;
  logic [DW-1:0] d_off;
  logic [LW-1:0] band_width, nearest_den;
  logic [psd_pkg::NORM_W-1:0] norm_sel, norm_eff;

  assign in_near     = (d_q <= {1'b0, near_limit_q});
  assign in_mid      = (d_q <= {1'b0, mid_limit_q});
  assign d_off       = d_q - {1'b0, near_limit_q};
  assign band_width  = mid_limit_q - near_limit_q;
  assign nearest_den = (nearest_limit_q == '0) ? LW'(1) : nearest_limit_q;
  assign norm_sel    = (kind_q == psd_pkg::KIND_NEAR) ? near_norm_q : mid_norm_q;
  assign norm_eff    = (norm_sel == '0) ? psd_pkg::NORM_W'(1) : norm_sel;

  // divider results turned into values
  logic [VW-1:0]  nv, w_near, w_mid, dens;
  logic           q_big;
  logic [AW:0]    acc_sum;
  logic [AW-1:0]  acc_new;

  assign q_big  = div_res.ovf || (div_res.quot > psd_pkg::ONE_Q16);
  assign nv     = q_big ? psd_pkg::ONE_Q16 : div_res.quot;
  assign dens   = nv;
  assign w_near = psd_pkg::ONE_Q16 - div_res.quot;
  assign w_mid  = q_big ? '0 : psd_pkg::ONE_Q16 - div_res.quot;
  assign acc_sum = band_mid_q ? ({1'b0, mid_rd} + (AW+1)'(w_mid))
                              : ({1'b0, near_rd} + (AW+1)'(w_near));
  assign acc_new = acc_sum[AW] ? psd_pkg::ACC_MAX : acc_sum[AW-1:0];

  logic emit_last;
  assign emit_last = (kind_q == psd_pkg::KIND_MID) && (sec_q == SEC_LAST);

  // next state and unit strobes
  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    sqrt_start   = 1'b0;
    cordic_start = 1'b0;
    div_num      = {d_q, 16'b0};
    div_den      = nearest_den;
    in_stall_o   = 1'b1;
    out_valid_o  = 1'b0;
    case (state_q)
      psd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_data_i.has_point) begin
            state_d = psd_pkg::ST_SQ_X;
          end else if (in_data_i.last_point) begin
            state_d = psd_pkg::ST_EMIT_PREP;
          end
        end
      end
      psd_pkg::ST_SQ_X: begin
        state_d = (dx_q == '0 && dy_q == '0) ? psd_pkg::ST_FINISH : psd_pkg::ST_SQ_Y;
      end
      psd_pkg::ST_SQ_Y:  state_d = psd_pkg::ST_START;
      psd_pkg::ST_START: begin
        sqrt_start   = 1'b1;
        cordic_start = 1'b1;
        state_d      = psd_pkg::ST_SOLVE;
      end
      // the root takes longer than the angle, so its done ends the wait
      psd_pkg::ST_SOLVE: begin
        if (sqrt_done) state_d = psd_pkg::ST_SECTOR;
      end
      psd_pkg::ST_SECTOR: state_d = psd_pkg::ST_NEAREST_START;
      psd_pkg::ST_NEAREST_START: begin
        div_start = 1'b1;
        state_d   = psd_pkg::ST_NEAREST_WAIT;
      end
      psd_pkg::ST_NEAREST_WAIT: begin
        if (div_res.done) begin
          state_d = (in_near || in_mid) ? psd_pkg::ST_BAND_START : psd_pkg::ST_FINISH;
        end
      end
      psd_pkg::ST_BAND_START: begin
        div_start = 1'b1;
        if (band_mid_q) begin
          div_num = {d_off, 16'b0};
          div_den = band_width;
        end else begin
          div_den = near_limit_q;
        end
        state_d = psd_pkg::ST_BAND_WAIT;
      end
      psd_pkg::ST_BAND_WAIT: begin
        if (div_res.done) state_d = psd_pkg::ST_FINISH;
      end
      psd_pkg::ST_FINISH: begin
        state_d = last_q ? psd_pkg::ST_EMIT_PREP : psd_pkg::ST_IDLE;
      end
      psd_pkg::ST_EMIT_PREP: begin
        if (kind_q == psd_pkg::KIND_NEAREST) begin
          state_d = psd_pkg::ST_EMIT_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = NW'({(kind_q == psd_pkg::KIND_NEAR) ? near_rd : mid_rd, 8'b0});
          div_den   = LW'(norm_eff);
          state_d   = psd_pkg::ST_EMIT_WAIT;
        end
      end
      psd_pkg::ST_EMIT_WAIT: begin
        if (div_res.done) state_d = psd_pkg::ST_EMIT_OUT;
      end
      psd_pkg::ST_EMIT_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = emit_last ? psd_pkg::ST_IDLE : psd_pkg::ST_EMIT_PREP;
        end
      end
      default: state_d = psd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control counters and bin valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      kind_q <= psd_pkg::KIND_NEAREST;
      sec_q  <= '0;
      last_q <= 1'b0;
    end else begin
      case (state_q)
        psd_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            last_q <= in_data_i.last_point;
            if (!in_data_i.has_point) begin
              kind_q <= psd_pkg::KIND_NEAREST;
              sec_q  <= '0;
            end
          end
        end
        psd_pkg::ST_SECTOR: sec_q <= sec_new;
        psd_pkg::ST_NEAREST_WAIT: begin
          if (div_res.done) vld_q[sec_q] <= 1'b1;
        end
        psd_pkg::ST_FINISH: begin
          kind_q <= psd_pkg::KIND_NEAREST;
          sec_q  <= '0;
        end
        psd_pkg::ST_EMIT_OUT: begin
          if (!out_stall_i) begin
            if (emit_last) begin
              vld_q  <= '0;
              kind_q <= psd_pkg::KIND_NEAREST;
              sec_q  <= '0;
            end else if (sec_q == SEC_LAST) begin
              sec_q  <= '0;
              kind_q <= (kind_q == psd_pkg::KIND_NEAREST) ? psd_pkg::KIND_NEAR
                                                          : psd_pkg::KIND_MID;
            end else begin
              sec_q <= sec_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      psd_pkg::ST_IDLE: begin
        dx_q <= psd_pkg::DELTA_W'(in_data_i.point_x) - psd_pkg::DELTA_W'($signed(center_x_q));
        dy_q <= psd_pkg::DELTA_W'(in_data_i.point_y) - psd_pkg::DELTA_W'($signed(center_y_q));
      end
      psd_pkg::ST_SQ_X: sum_q <= psd_pkg::SUMSQ_W'(square);
      psd_pkg::ST_SQ_Y: sum_q <= sum_q + psd_pkg::SUMSQ_W'(square);
      psd_pkg::ST_SOLVE: begin
        if (sqrt_done) d_q <= root;
      end
      psd_pkg::ST_NEAREST_WAIT: begin
        if (div_res.done) begin
          nearest_q[sec_q]  <= (nv < nearest_rd) ? nv : nearest_rd;
          near_acc_q[sec_q] <= near_rd;
          mid_acc_q[sec_q]  <= mid_rd;
          band_mid_q        <= !in_near;
        end
      end
      psd_pkg::ST_BAND_WAIT: begin
        if (div_res.done) begin
          if (band_mid_q) mid_acc_q[sec_q] <= acc_new;
          else            near_acc_q[sec_q] <= acc_new;
        end
      end
      psd_pkg::ST_EMIT_PREP: begin
        if (kind_q == psd_pkg::KIND_NEAREST) val_q <= nearest_rd;
      end
      psd_pkg::ST_EMIT_WAIT: begin
        if (div_res.done) val_q <= dens;
      end
      default: ;
    endcase
  end

  // result item
  assign out_data_o.feature_kind  = kind_q;
  assign out_data_o.sector        = psd_pkg::SEC_OUT_W'(sec_q);
  assign out_data_o.feature_value = val_q;
  assign out_data_o.last_result   = emit_last;

  logic unused_cordic_done;
  assign unused_cordic_done = cordic_done;

endmodule

>>> rtl/psd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the polar sector density block, bound to the top.
// ----------------------------------------------------------------------------
module psd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input psd_pkg::out_item_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // no item is taken while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("item accepted during emission");

  // result values stay within one and kinds are defined
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.feature_value <= psd_pkg::ONE_Q16) &&
                    (out_data_o.feature_kind != 2'd3))
    else $error("result out of range");

  // each result is shown once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result repeated");

endmodule

bind polar_sector_density_features_core psd_checker u_psd_checker (.*);
